### src/hccr_pkg.sv
// Shared types and constants for the HID control channel responder.
`default_nettype none
package hccr_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 128;
  localparam int unsigned POS_W             = 8;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W       = QUEUE_PTR_W + 1;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_CTRL_UP = 2'd1,
    OP_INTR_UP = 2'd2,
    OP_DISC    = 2'd3
  } op_t;

  localparam logic [3:0] MSG_HANDSHAKE    = 4'h0;
  localparam logic [3:0] MSG_CONTROL      = 4'h1;
  localparam logic [3:0] MSG_GET_REPORT   = 4'h4;
  localparam logic [3:0] MSG_SET_REPORT   = 4'h5;
  localparam logic [3:0] MSG_GET_PROTOCOL = 4'h6;
  localparam logic [3:0] MSG_SET_PROTOCOL = 4'h7;

  localparam logic [3:0] PARAM_UNPLUG       = 4'h5;
  localparam logic [1:0] REPORT_TYPE_OUTPUT = 2'd2;
  localparam logic [7:0] LED_REPORT_ID      = 8'h01;

  localparam logic [7:0] REPLY_SUCCESS     = 8'h00;
  localparam logic [7:0] REPLY_UNSUPPORTED = 8'h03;
  localparam logic [7:0] REPLY_PROTOCOL    = 8'hA3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       link_connected;
    logic       report_protocol;
    logic [7:0] keyboard_leds;
    logic       link_dropped;
  } out_item_t;

  // One queued job: the answer to one item, one or two result items.
  typedef struct packed {
    logic       two_results;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       link_dropped;
    logic       link_connected;
    logic       report_protocol;
    logic [7:0] keyboard_leds;
  } job_t;

endpackage
`default_nettype wire

### src/hccr_front.sv
// Front end: takes items, tracks link and message state, builds answer jobs.
`default_nettype none
module hccr_front import hccr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          job_push,
  output job_t          job
);

  logic             ctrl_up_r, ctrl_up_nxt;
  logic             intr_up_r, intr_up_nxt;
  logic             conn_r, conn_nxt;
  logic             proto_r, proto_nxt;
  logic [7:0]       led_r, led_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       header_r, header_nxt;
  logic [7:0]       report_r, report_nxt;

  logic [7:0] hdr;
  logic       out_set_report;
  logic       dropped;

  assign out_set_report = (header_r[7:4] == MSG_SET_REPORT) &&
                          (header_r[1:0] == REPORT_TYPE_OUTPUT);

  always_comb begin
    ctrl_up_nxt = ctrl_up_r;
    intr_up_nxt = intr_up_r;
    conn_nxt    = conn_r;
    proto_nxt   = proto_r;
    led_nxt     = led_r;
    pos_nxt     = pos_r;
    header_nxt  = header_r;
    report_nxt  = report_r;
    job_push    = 1'b0;
    dropped     = 1'b0;
    job         = '0;
    hdr         = (pos_r == '0) ? item.byte_value : header_r;

    unique case (op_t'(item.op))
      OP_CTRL_UP: begin
        ctrl_up_nxt = 1'b1;
        pos_nxt     = '0;
        job_push    = 1'b1;
      end
      OP_INTR_UP: begin
        intr_up_nxt = 1'b1;
        if (ctrl_up_r) begin
          conn_nxt  = 1'b1;
          proto_nxt = 1'b1;
        end
        job_push = 1'b1;
      end
      OP_DISC: begin
        dropped  = 1'b1;
        job_push = 1'b1;
      end
      default: begin
        if (pos_r < POS_W'(MAX_MESSAGE_BYTES)) begin
          if (pos_r == POS_W'(0)) begin
            header_nxt = item.byte_value;
          end else if (pos_r == POS_W'(1)) begin
            report_nxt = item.byte_value;
            if (out_set_report && !header_r[3]) begin
              led_nxt = item.byte_value;
            end
          end else if (pos_r == POS_W'(2)) begin
            if (out_set_report && header_r[3] && report_r == LED_REPORT_ID) begin
              led_nxt = item.byte_value;
            end
          end
          pos_nxt = pos_r + POS_W'(1);
        end
        if (item.last_byte) begin
          pos_nxt          = '0;
          job_push         = 1'b1;
          job.reply_valid  = 1'b1;
          job.reply_byte   = REPLY_SUCCESS;
          case (hdr[7:4])
            MSG_HANDSHAKE: job.reply_valid = 1'b0;
            MSG_CONTROL: begin
              if (hdr[3:0] == PARAM_UNPLUG) begin
                dropped = 1'b1;
              end
            end
            MSG_GET_REPORT:   job.reply_byte  = REPLY_UNSUPPORTED;
            MSG_GET_PROTOCOL: begin
              job.reply_byte  = REPLY_PROTOCOL;
              job.two_results = 1'b1;
            end
            MSG_SET_PROTOCOL: proto_nxt = hdr[0];
            default: ;
          endcase
        end
      end
    endcase

    if (dropped) begin
      ctrl_up_nxt = 1'b0;
      intr_up_nxt = 1'b0;
      conn_nxt    = 1'b0;
      proto_nxt   = 1'b1;
      led_nxt     = '0;
      pos_nxt     = '0;
    end

    job.link_dropped    = dropped;
    job.link_connected  = conn_nxt;
    job.report_protocol = proto_nxt;
    job.keyboard_leds   = led_nxt;
    job_push            = job_push & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_up_r <= 1'b0;
      intr_up_r <= 1'b0;
      conn_r    <= 1'b0;
      proto_r   <= 1'b1;
      led_r     <= '0;
      pos_r     <= '0;
      report_r  <= '0;
    end else if (accept) begin
      ctrl_up_r <= ctrl_up_nxt;
      intr_up_r <= intr_up_nxt;
      conn_r    <= conn_nxt;
      proto_r   <= proto_nxt;
      led_r     <= led_nxt;
      pos_r     <= pos_nxt;
      report_r  <= report_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_r <= header_nxt;
    end
  end

endmodule
`default_nettype wire

### src/hccr_queue.sv
// Short job queue between front and back ends.
`default_nettype none
module hccr_queue import hccr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      empty
);

  job_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_wr, do_rd;

  assign full   = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

### src/hccr_back.sv
// Back end: expands queued jobs into result items behind an output register.
`default_nettype none
module hccr_back import hccr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t job,
  input  wire logic job_empty,
  output logic      job_pop,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      phase_r, phase_nxt;
  logic      load;

  assign load     = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    phase_nxt     = phase_r;
    job_pop       = 1'b0;
    if (load) begin
      out_valid_nxt = !job_empty;
      if (!job_empty) begin
        out_nxt.link_connected  = job.link_connected;
        out_nxt.report_protocol = job.report_protocol;
        out_nxt.keyboard_leds   = job.keyboard_leds;
        if (phase_r) begin
          out_nxt.reply_valid  = 1'b1;
          out_nxt.reply_byte   = {7'd0, job.report_protocol};
          out_nxt.reply_last   = 1'b1;
          out_nxt.link_dropped = 1'b0;
          phase_nxt            = 1'b0;
          job_pop              = 1'b1;
        end else begin
          out_nxt.reply_valid  = job.reply_valid;
          out_nxt.reply_byte   = job.reply_valid ? job.reply_byte : 8'd0;
          out_nxt.reply_last   = !job.two_results;
          out_nxt.link_dropped = job.link_dropped;
          phase_nxt            = job.two_results;
          job_pop              = !job.two_results;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

### src/hid_control_channel_responder.sv
// Top level of the HID control channel responder.
//
// Input channel: push/full. An item (op, byte_value, last_byte) is taken on a
// clock edge with push high and full low. Control bytes build a message; the
// byte marked last triggers the answer. Link events answer at once.
// Result channel: empty/pop. The oldest result sits on out_data while empty
// is low and leaves on an edge with pop high.
// A result passes the job queue and the output register: the front end
// updates state and queues a job at the edge that takes the item, and the
// back end loads the output register from the queue once that register is free.
// Throughput: one item per cycle while full is low; a get protocol answer
// holds the back end for two result items. A non-last control byte yields none.
// A four-entry job queue sits between front and back; full rises when that
// queue fills, either from a stalled receiver or from a run of get protocol
// answers, each of which yields two result items from one job.
// Reset (rst_n low, synchronous): link flags cleared, protocol mode report,
// LED byte zero, message position zero, queue and output register empty.
`default_nettype none
module hid_control_channel_responder import hccr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_data
);

  logic accept;
  logic job_push;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_out;

  assign accept = push && !full;

  hccr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  hccr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job_in),
    .full   (full),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .empty  (job_empty)
  );

  hccr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### src/hccr_checker.sv
// Port-level checks for the HID control channel responder, with bind.
`default_nettype none
module hccr_checker import hccr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("stalled item changed");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.reply_valid |-> out_data.reply_byte == 8'd0)
    else $error("reply byte set without reply");

  a_drop_state: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.link_dropped |->
      !out_data.link_connected && out_data.report_protocol &&
      out_data.keyboard_leds == 8'd0)
    else $error("link drop left state behind");

  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.reply_last |->
      out_data.reply_valid && out_data.reply_byte == REPLY_PROTOCOL)
    else $error("unexpected non-last item");

endmodule

bind hid_control_channel_responder hccr_checker u_hccr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
`default_nettype wire

### test/hid_control_channel_responder_test.sv
`timescale 1ns / 1ps
// Testbench for the HID control channel responder: directed and random items against a scoreboard.
module hid_control_channel_responder_test;
  import hccr_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1400;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      push  = 1'b0;
  logic      pop   = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_data = '0;
  out_item_t out_data;

  // device state as the host link sees it
  logic       ctrl_up    = 1'b0;
  logic       intr_up    = 1'b0;
  logic       connected  = 1'b0;
  logic       proto_mode = 1'b1;
  logic [7:0] leds       = 8'h00;
  logic [7:0] msg_pos    = 8'h00;
  logic [7:0] hdr        = 8'h00;
  logic [7:0] report_num = 8'h00;

  out_item_t   pending_results[$];
  int unsigned items_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        steady      = 1'b0;

  hid_control_channel_responder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hid_control_channel_responder test failed");
      $finish;
    end
  end

  function automatic void expect_reply(logic valid, logic [7:0] value, logic last,
                                       logic dropped);
    out_item_t r;
    r.reply_valid     = valid;
    r.reply_byte      = valid ? value : 8'h00;
    r.reply_last      = last;
    r.link_connected  = connected;
    r.report_protocol = proto_mode;
    r.keyboard_leds   = leds;
    r.link_dropped    = dropped;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_connection();
    ctrl_up    = 1'b0;
    intr_up    = 1'b0;
    connected  = 1'b0;
    proto_mode = 1'b1;
    leds       = 8'h00;
    msg_pos    = 8'h00;
  endfunction

  function automatic void predict_item(in_item_t it);
    logic out_report;
    out_report = hdr[7:4] == MSG_SET_REPORT && hdr[1:0] == REPORT_TYPE_OUTPUT;
    case (it.op)
      OP_CTRL_UP: begin
        ctrl_up = 1'b1;
        msg_pos = 8'h00;
        expect_reply(1'b0, 8'h00, 1'b1, 1'b0);
      end
      OP_INTR_UP: begin
        intr_up = 1'b1;
        if (ctrl_up) begin
          connected  = 1'b1;
          proto_mode = 1'b1;
        end
        expect_reply(1'b0, 8'h00, 1'b1, 1'b0);
      end
      OP_DISC: begin
        drop_connection();
        expect_reply(1'b0, 8'h00, 1'b1, 1'b1);
      end
      default: begin
        // bytes past the length limit are dropped, but a last mark still counts
        if (msg_pos < MAX_MESSAGE_BYTES) begin
          if (msg_pos == 8'd0) begin
            hdr = it.byte_value;
          end else if (msg_pos == 8'd1) begin
            report_num = it.byte_value;
            if (out_report && !hdr[3]) leds = it.byte_value;
          end else if (msg_pos == 8'd2) begin
            if (out_report && hdr[3] && report_num == LED_REPORT_ID) leds = it.byte_value;
          end
          msg_pos = msg_pos + 8'd1;
        end
        if (it.last_byte) begin
          msg_pos = 8'h00;
          case (hdr[7:4])
            MSG_HANDSHAKE: expect_reply(1'b0, 8'h00, 1'b1, 1'b0);
            MSG_CONTROL: begin
              if (hdr[3:0] == PARAM_UNPLUG) begin
                drop_connection();
                expect_reply(1'b1, REPLY_SUCCESS, 1'b1, 1'b1);
              end else begin
                expect_reply(1'b1, REPLY_SUCCESS, 1'b1, 1'b0);
              end
            end
            MSG_GET_REPORT: expect_reply(1'b1, REPLY_UNSUPPORTED, 1'b1, 1'b0);
            MSG_GET_PROTOCOL: begin
              expect_reply(1'b1, REPLY_PROTOCOL, 1'b0, 1'b0);
              expect_reply(1'b1, {7'd0, proto_mode}, 1'b1, 1'b0);
            end
            MSG_SET_PROTOCOL: begin
              proto_mode = hdr[0];
              expect_reply(1'b1, REPLY_SUCCESS, 1'b1, 1'b0);
            end
            default: expect_reply(1'b1, REPLY_SUCCESS, 1'b1, 1'b0);
          endcase
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result item with none expected: %h", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("reply_valid", want.reply_valid, out_data.reply_valid);
        check_field("reply_byte", want.reply_byte, out_data.reply_byte);
        check_field("reply_last", want.reply_last, out_data.reply_last);
        check_field("link_connected", want.link_connected, out_data.link_connected);
        check_field("report_protocol", want.report_protocol, out_data.report_protocol);
        check_field("keyboard_leds", want.keyboard_leds, out_data.keyboard_leds);
        check_field("link_dropped", want.link_dropped, out_data.link_dropped);
      end
    end
    pop <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  function automatic in_item_t make_item(op_t op, logic [7:0] b, logic last);
    in_item_t it;
    it.op         = op;
    it.byte_value = b;
    it.last_byte  = last;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push    <= 1'b0;
      in_data <= make_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_item(make_item(OP_BYTE, b, last));
  endtask

  task automatic send_event(input op_t op);
    send_item(make_item(op, 8'($urandom_range(255)), 1'($urandom_range(1))));
  endtask

  // finish = 0 leaves the message open
  task automatic send_message(input logic [7:0] header, input int unsigned len,
                              input logic finish);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) b = header;
      else if (i == 1 && $urandom_range(1) == 1) b = LED_REPORT_ID;
      else b = 8'($urandom_range(255));
      send_byte(b, finish && i == len - 1);
    end
  endtask

  function automatic logic [7:0] random_header();
    logic [7:0] h;
    h = 8'($urandom_range(255));
    case ($urandom_range(9))
      2, 3: begin
        h[7:4] = MSG_SET_REPORT;
        h[1:0] = REPORT_TYPE_OUTPUT;
      end
      4: h[7:4] = MSG_GET_PROTOCOL;
      5: h[7:4] = MSG_SET_PROTOCOL;
      6: begin
        h[7:4] = MSG_CONTROL;
        if ($urandom_range(1) == 1) h[3:0] = PARAM_UNPLUG;
      end
      7: h[7:4] = MSG_GET_REPORT;
      8: h[7:4] = MSG_HANDSHAKE;
      default: ;
    endcase
    return h;
  endfunction

  function automatic op_t random_event();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return OP_CTRL_UP;
    if (pick < 8) return OP_INTR_UP;
    return OP_DISC;
  endfunction

  task automatic test_link_events();
    send_event(OP_INTR_UP);
    send_event(OP_CTRL_UP);
    send_event(OP_INTR_UP);
    send_event(OP_DISC);
    send_event(OP_CTRL_UP);
    send_event(OP_INTR_UP);
  endtask

  task automatic test_message_types();
    send_byte({MSG_HANDSHAKE, 4'h0}, 1'b1);
    send_byte({MSG_SET_PROTOCOL, 4'h0}, 1'b1);
    send_byte({MSG_GET_PROTOCOL, 4'h0}, 1'b1);
    send_byte({MSG_SET_PROTOCOL, 4'hF}, 1'b1);
    send_byte({MSG_GET_PROTOCOL, 4'h0}, 1'b1);
    send_byte({MSG_GET_REPORT, 4'h1}, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte({MSG_CONTROL, 4'h3}, 1'b1);
  endtask

  task automatic test_led_reports();
    send_byte({MSG_SET_REPORT, 4'h2}, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte({MSG_SET_REPORT, 4'hA}, 1'b0);
    send_byte(LED_REPORT_ID, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte({MSG_SET_REPORT, 4'hA}, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte({MSG_SET_REPORT, 4'h1}, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_link_drops();
    send_byte({MSG_CONTROL, PARAM_UNPLUG}, 1'b1);
    // control link up in mid message starts a fresh one
    send_byte({MSG_SET_REPORT, 4'h2}, 1'b0);
    send_event(OP_CTRL_UP);
    send_byte(8'h00, 1'b1);
    send_byte({MSG_GET_PROTOCOL, 4'h0}, 1'b0);
    send_event(OP_DISC);
  endtask

  task automatic test_long_messages();
    send_event(OP_CTRL_UP);
    send_event(OP_INTR_UP);
    send_message({MSG_SET_REPORT, 4'hA}, MAX_MESSAGE_BYTES - 1, 1'b1);
    send_message({MSG_SET_PROTOCOL, 4'h0}, MAX_MESSAGE_BYTES, 1'b1);
    send_message({MSG_GET_PROTOCOL, 4'h0}, MAX_MESSAGE_BYTES + 1, 1'b1);
    send_message({MSG_SET_REPORT, 4'h6}, MAX_MESSAGE_BYTES + 2, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned len;
    while (items_sent < ITEM_TARGET) begin
      steady = items_sent >= 800 && items_sent < 1000;
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
      if (pick < 10) begin
        send_event(random_event());
      end else if (pick < 14) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 20) begin
        send_message(random_header(), len, 1'b0);
        send_event(random_event());
      end else begin
        send_message(random_header(), len, 1'b1);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_link_events();
    test_message_types();
    test_led_reports();
    test_link_drops();
    test_long_messages();
    test_random_traffic();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("hid_control_channel_responder test passed");
    end else begin
      $display("hid_control_channel_responder test failed");
    end
    $finish;
  end

endmodule
